@@ rtl/gtl_pkg.sv @@
// shared types and constants for the glyph text layout block
package gtl_pkg;

   localparam logic [15:0] CODE_CR = 16'h000D;
   localparam logic [15:0] CODE_LF = 16'h000A;

   localparam logic [1:0] KIND_STORED = 2'd0;
   localparam logic [1:0] KIND_SPRITE = 2'd1;
   localparam logic [1:0] KIND_BLANK  = 2'd2;
   localparam logic [1:0] KIND_NONE   = 2'd3;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_LAYOUT = 1'b1;

   localparam logic [1:0] REG_GLYPH_COUNT  = 2'd0;
   localparam logic [1:0] REG_LINE_SPACE   = 2'd1;
   localparam logic [1:0] REG_DEFAULT_CHAR = 2'd2;

   localparam int ENTRY_W = 112;   // code 16, rect 48, metrics 48

   typedef struct packed {
      logic        func;
      logic [7:0]  entry_index;
      logic [15:0] char_code;
      logic [11:0] rect_left;
      logic [11:0] rect_top;
      logic [11:0] rect_right;
      logic [11:0] rect_bottom;
      logic signed [15:0] glyph_offset_x;
      logic signed [15:0] glyph_offset_y;
      logic signed [15:0] glyph_advance;
      logic        end_of_text;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic signed [19:0] sprite_x;
      logic signed [19:0] sprite_y;
      logic [11:0] src_left;
      logic [11:0] src_top;
      logic [11:0] src_right;
      logic [11:0] src_bottom;
      logic [18:0] extent_width;
      logic [18:0] extent_height;
      logic        text_done;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_CR,
      CMD_LF,
      CMD_GLYPH
   } cmd_type;

   // classified request passed from front to back
   typedef struct packed {
      cmd_type     cmd;
      logic        white;
      logic        done;
      logic [15:0] code;
   } work_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CHECK,
      ST_FETCH,
      ST_APPLY,
      ST_SEND
   } state_type;

   function automatic logic is_white(input logic [15:0] c);
      return (c >= 16'h0009 && c <= 16'h000D) || c == 16'h0020 || c == 16'h0085 ||
             c == 16'h00A0 || c == 16'h1680 || (c >= 16'h2000 && c <= 16'h200A) ||
             c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
             c == 16'h3000;
   endfunction

   function automatic logic signed [19:0] sat_s20(input logic signed [21:0] v);
      if (v > 22'sd524287) return 20'sh7FFFF;
      if (v < -22'sd524288) return 20'sh80000;
      return v[19:0];
   endfunction

   function automatic logic [18:0] sat_u19(input logic signed [21:0] v);
      if (v > 22'sd524287) return 19'h7FFFF;
      if (v < 22'sd0) return 19'd0;
      return v[18:0];
   endfunction

endpackage

@@ rtl/gtl_ram.sv @@
// generic single-port RAM with registered read
module gtl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/gtl_front.sv @@
// request intake: classification and a two-entry queue toward the back end
module gtl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gtl_pkg::req_type  req_data,
   output logic              q_valid,
   input  logic              q_pop,
   output gtl_pkg::work_type q_work
);
   import gtl_pkg::*;

   work_type   slot_ff [2];
   work_type   slot_in;
   logic       rd_ff, wr_ff, rd_in, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   always_comb begin
      slot_in.code  = req_data.char_code;
      slot_in.done  = req_data.end_of_text;
      slot_in.white = is_white(req_data.char_code);
      if (req_data.func == FUNC_LOAD) begin
         slot_in.cmd = CMD_LOAD;
      end else if (req_data.char_code == CODE_CR) begin
         slot_in.cmd = CMD_CR;
      end else if (req_data.char_code == CODE_LF) begin
         slot_in.cmd = CMD_LF;
      end else begin
         slot_in.cmd = CMD_GLYPH;
      end
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_work    = slot_ff[rd_ff];

   always_comb begin
      rd_in  = q_pop ? ~rd_ff : rd_ff;
      wr_in  = push ? ~wr_ff : wr_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

@@ rtl/gtl_back.sv @@
// back end: glyph table, binary search, pen update and result register
module gtl_back #(
   parameter int GLYPH_ENTRIES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_pop,
   input  gtl_pkg::work_type q_work,
   input  gtl_pkg::req_type  load_data,
   input  logic              load_valid,
   output logic              load_stall,
   input  logic [8:0]        glyph_count,
   input  logic [15:0]       line_space,
   input  logic [15:0]       default_char,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gtl_pkg::rsp_type  rsp_data
);
   import gtl_pkg::*;

   localparam int AW = $clog2(GLYPH_ENTRIES);
   localparam int NW = AW + 1;

   state_type  state_ff, state_in;
   logic [NW-1:0] lo_ff, lo_in, hi_ff, hi_in, n_ff, n_in;
   logic [15:0] key_ff, key_in;
   logic        fallback_ff, fallback_in;
   logic signed [19:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [18:0] mw_ff, mw_in, mh_ff, mh_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rv_ff, rv_in;

   logic              ram_we;
   logic [AW-1:0]     ram_addr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
   logic [NW-1:0]     mid;
   logic [15:0]       rd_code;
   logic [NW:0]       sum;

   // load items bypass the queue payload: the table entry comes from the held request
   gtl_ram #(.WIDTH(ENTRY_W), .DEPTH(GLYPH_ENTRIES)) u_table (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   assign ram_wdata = {load_data.char_code,
                       load_data.rect_bottom, load_data.rect_right,
                       load_data.rect_top, load_data.rect_left,
                       load_data.glyph_advance, load_data.glyph_offset_y,
                       load_data.glyph_offset_x};
   assign rd_code = ram_rdata[ENTRY_W-1 -: 16];
   assign sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = sum[NW:1];

   // decode of the fetched entry
   logic [11:0] e_l, e_t, e_r, e_b;
   logic signed [15:0] e_ox, e_oy, e_adv;
   logic signed [21:0] w, h, x, xc, hh, cw, ch;
   logic signed [19:0] xs, oys;
   always_comb begin
      {e_b, e_r, e_t, e_l} = ram_rdata[95:48];
      e_adv = ram_rdata[47:32];
      e_oy  = ram_rdata[31:16];
      e_ox  = ram_rdata[15:0];
      w   = ($signed({10'd0, e_r}) - $signed({10'd0, e_l})) <<< 4;
      h   = ($signed({10'd0, e_b}) - $signed({10'd0, e_t})) <<< 4;
      xs  = sat_s20(22'(cx_ff) + 22'(e_ox));
      oys = sat_s20(22'(cy_ff) + 22'(e_oy));
      x   = 22'(xs);
      xc  = x[21] ? 22'sd0 : x;
      hh  = h + 22'(e_oy);
      if (hh < $signed({6'd0, line_space})) begin
         hh = $signed({6'd0, line_space});
      end
      cw  = xc + w;
      ch  = 22'(cy_ff) + hh;
   end

   always_comb begin
      state_in    = state_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      n_in        = n_ff;
      key_in      = key_ff;
      fallback_in = fallback_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      mw_in       = mw_ff;
      mh_in       = mh_ff;
      rsp_in      = rsp_ff;
      rv_in       = rv_ff && rsp_stall;
      q_pop       = 1'b0;
      ram_we      = 1'b0;
      ram_addr    = mid[AW-1:0];
      load_stall  = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && !(rv_ff && rsp_stall)) begin
               rsp_in               = '0;
               rsp_in.extent_width  = mw_ff;
               rsp_in.extent_height = mh_ff;
               rsp_in.kind          = KIND_BLANK;
               if (int'(glyph_count) > GLYPH_ENTRIES) begin
                  n_in = NW'(GLYPH_ENTRIES);
               end else begin
                  n_in = NW'(glyph_count);
               end
               case (q_work.cmd)
                  CMD_LOAD: begin
                     if (load_valid) begin
                        load_stall = 1'b0;
                        ram_addr   = AW'(load_data.entry_index);
                        ram_we     = (int'(load_data.entry_index) < GLYPH_ENTRIES);
                        rsp_in.kind = KIND_STORED;
                        state_in    = ST_SEND;
                     end
                  end
                  CMD_CR: begin
                     rsp_in.text_done = q_work.done;
                     state_in = ST_SEND;
                  end
                  CMD_LF: begin
                     cx_in = '0;
                     cy_in = sat_s20(22'(cy_ff) + $signed({6'd0, line_space}));
                     rsp_in.text_done = q_work.done;
                     state_in = ST_SEND;
                  end
                  default: begin
                     key_in      = q_work.code;
                     fallback_in = 1'b0;
                     lo_in       = '0;
                     hi_in       = n_in;
                     state_in    = ST_PROBE;
                  end
               endcase
            end
         end
         ST_PROBE: begin
            // read code[mid] while lo < hi, else read code[lo] for the match check
            if (lo_ff < hi_ff) begin
               ram_addr = mid[AW-1:0];
               state_in = ST_CHECK;
            end else begin
               ram_addr = lo_ff[AW-1:0];
               state_in = ST_FETCH;
            end
         end
         ST_CHECK: begin
            if (rd_code < key_ff) begin
               lo_in = mid + NW'(1);
            end else begin
               hi_in = mid;
            end
            state_in = ST_PROBE;
         end
         ST_FETCH: begin
            if (lo_ff < n_ff && rd_code == key_ff) begin
               state_in = ST_APPLY;
            end else if (!fallback_ff && default_char != 16'd0) begin
               fallback_in = 1'b1;
               key_in      = default_char;
               lo_in       = '0;
               hi_in       = n_ff;
               state_in    = ST_PROBE;
            end else begin
               rsp_in.kind      = KIND_NONE;
               rsp_in.text_done = q_work.done;
               state_in         = ST_SEND;
            end
         end
         ST_APPLY: begin
            if (!q_work.white) begin
               rsp_in.kind       = KIND_SPRITE;
               rsp_in.sprite_x   = xs;
               rsp_in.sprite_y   = oys;
               rsp_in.src_left   = e_l;
               rsp_in.src_top    = e_t;
               rsp_in.src_right  = e_r;
               rsp_in.src_bottom = e_b;
               if (sat_u19(cw) > mw_ff) begin
                  mw_in = sat_u19(cw);
                  rsp_in.extent_width = sat_u19(cw);
               end
               if (sat_u19(ch) > mh_ff) begin
                  mh_in = sat_u19(ch);
                  rsp_in.extent_height = sat_u19(ch);
               end
            end
            cx_in = sat_s20(xc + w + 22'(e_adv));
            rsp_in.text_done = q_work.done;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            rv_in = 1'b1;
            q_pop = 1'b1;
            if (rsp_ff.text_done) begin
               cx_in = '0;
               cy_in = '0;
               mw_in = '0;
               mh_in = '0;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      n_ff        <= n_in;
      fallback_ff <= fallback_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         mw_ff    <= '0;
         mh_ff    <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         mw_ff    <= mw_in;
         mh_ff    <= mh_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;
endmodule

@@ rtl/glyph_text_layout.sv @@
// top level of the glyph text layout block
// Lays out text with a bitmap font held in a table of up to GLYPH_ENTRIES glyphs sorted by
// code. Load requests (func 0) write one table entry, and a load holds off further requests
// until its entry is written. Any character other than CR or LF is found by binary search
// through the single-port table RAM; if it is not found and default_char is nonzero, the
// default character is searched for in the same way. The back end can take the next request
// while a result is presented, unless that result is stalled. A two-entry request queue lets
// new requests be taken while the back end works and a result waits. Registers: glyph_count
// at 0x0, line_space at 0x4, default_char at 0x8; write them only while idle.
module glyph_text_layout #(
   parameter int GLYPH_ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gtl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gtl_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import gtl_pkg::*;

   logic [8:0]  count_ff;
   logic [15:0] space_ff, dflt_ff;
   logic [1:0]  reg_sel;
   logic        wr;
   logic        q_valid, q_pop, front_stall;
   work_type    q_work;
   req_type     held_ff;
   logic        load_stall;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[3:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (reg_sel)
         REG_GLYPH_COUNT:  csr_prdata = {23'd0, count_ff};
         REG_LINE_SPACE:   csr_prdata = {16'd0, space_ff};
         REG_DEFAULT_CHAR: csr_prdata = {16'd0, dflt_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         space_ff <= '0;
         dflt_ff  <= '0;
      end else if (wr) begin
         case (reg_sel)
            REG_GLYPH_COUNT:  count_ff <= csr_pwdata[8:0];
            REG_LINE_SPACE:   space_ff <= csr_pwdata[15:0];
            REG_DEFAULT_CHAR: dflt_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // only one item is in the back end at a time, so a copy of the last load request suffices
   logic load_pend_ff;
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall && req_data.func == FUNC_LOAD) begin
         held_ff <= req_data;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         load_pend_ff <= 1'b0;
      end else if (req_valid && !req_stall && req_data.func == FUNC_LOAD) begin
         load_pend_ff <= 1'b1;
      end else if (!load_stall) begin
         load_pend_ff <= 1'b0;
      end
   end

   // hold off further requests until the pending load has been written
   assign req_stall = front_stall || load_pend_ff;

   gtl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid && !load_pend_ff),
      .req_stall(front_stall),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_work   (q_work)
   );

   gtl_back #(.GLYPH_ENTRIES(GLYPH_ENTRIES)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_work      (q_work),
      .load_data   (held_ff),
      .load_valid  (load_pend_ff),
      .load_stall  (load_stall),
      .glyph_count (count_ff),
      .line_space  (space_ff),
      .default_char(dflt_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );
endmodule
